>>> src/fqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqd_pkg: shared types and constants for the handle queue with delete
// depth, widths and the codes of actions, status and controller states
// ----------------------------------------------------------------------------
package fqd_pkg;

    // depth must be a power of two: slot indexes wrap by truncation
    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_QUERY   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SCAN,
        ST_SHIFT
    } state_t;

endpackage

>>> src/fifo_queue_with_delete_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_delete_top: bounded fifo of nonzero handles with delete
// entries live in one synchronous memory; a small controller reads,
// compares and moves entries to serve each item
// ----------------------------------------------------------------------------
// enqueue, query and items rejected without a scan load the result when taken; dequeue
// reads the head entry, then returns it from ST_DEQ; delete scans from the oldest entry up
//   to the match, then moves each entry behind it down one slot; an absent handle scans all
// throughput: one item at a time; the next item is taken as soon as the result
//   register can be freed, so enqueues and queries can follow every cycle while m_tready is high
// reset: aresetn (synchronous, active low) empties the queue; memory not cleared
module fifo_queue_with_delete_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[1:0], value[33:2], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], out_value[33:2], count[38:34], zero pad
);

    localparam int PB = fqd_pkg::PTR_BITS;
    localparam int CB = fqd_pkg::CNT_BITS;
    localparam int VB = fqd_pkg::VALUE_BITS;

    // entry storage, one write and one registered read port
    logic [VB-1:0] entry_mem [fqd_pkg::DEPTH];
    logic          mem_we;
    logic [PB-1:0] mem_waddr;
    logic [VB-1:0] mem_wdata;
    logic          mem_re;
    logic [PB-1:0] mem_raddr;
    logic [VB-1:0] mem_rdata_reg;

    // control state
    fqd_pkg::state_t state_reg, state_next;
    logic [PB-1:0]   head_reg, head_next;
    logic [CB-1:0]   count_reg, count_next;
    logic [PB-1:0]   idx_reg, idx_next;     // offset from head of the entry in flight
    logic [VB-1:0]   key_reg, key_next;     // handle being deleted

    // result register
    logic              m_tvalid_reg;
    fqd_pkg::status_t  res_status_reg;
    logic [VB-1:0]     res_value_reg;
    logic [CB-1:0]     res_count_reg;

    logic              res_load;
    fqd_pkg::status_t  res_status;
    logic [VB-1:0]     res_value;
    logic [CB-1:0]     res_count;

    fqd_pkg::action_t in_action;
    logic [VB-1:0]    in_value;
    logic             accept;
    logic [CB-1:0]    idx_inc1;
    logic [CB-1:0]    idx_inc2;

    assign in_action = fqd_pkg::action_t'(s_tdata[1:0]);
    assign in_value  = s_tdata[33:2];
    assign accept    = s_tvalid && s_tready;
    assign idx_inc1  = {1'b0, idx_reg} + CB'(1);
    assign idx_inc2  = {1'b0, idx_reg} + CB'(2);

    // a new item enters only when the controller is free and the result slot
    // is empty or emptied this cycle, so multi-cycle work always finds it free
    assign s_tready = (state_reg == fqd_pkg::ST_IDLE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        mem_we     = 1'b0;
        mem_waddr  = head_reg + count_reg[PB-1:0];
        mem_wdata  = in_value;
        mem_re     = 1'b0;
        mem_raddr  = head_reg;
        res_load   = 1'b0;
        res_status = fqd_pkg::STAT_OK;
        res_value  = '0;
        res_count  = count_reg;

        unique case (state_reg)
            fqd_pkg::ST_IDLE: begin
                if (accept) begin
                    key_next = in_value;
                    unique case (in_action)
                        fqd_pkg::ACT_ENQUEUE: begin
                            res_load = 1'b1;
                            if (in_value == '0) begin
                                res_status = fqd_pkg::STAT_REJECT;
                            end else if (count_reg == fqd_pkg::FULL_COUNT) begin
                                res_status = fqd_pkg::STAT_FULL;
                            end else begin
                                // write behind the tail
                                mem_we     = 1'b1;
                                count_next = count_reg + CB'(1);
                                res_count  = count_next;
                            end
                        end
                        fqd_pkg::ACT_DEQUEUE: begin
                            if (count_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = fqd_pkg::STAT_REJECT;
                            end else begin
                                mem_re     = 1'b1;
                                state_next = fqd_pkg::ST_DEQ;
                            end
                        end
                        fqd_pkg::ACT_DELETE: begin
                            if (in_value == '0 || count_reg == '0) begin
                                res_load   = 1'b1;
                                res_status = fqd_pkg::STAT_REJECT;
                            end else begin
                                // start scanning from the oldest entry
                                mem_re     = 1'b1;
                                idx_next   = '0;
                                state_next = fqd_pkg::ST_SCAN;
                            end
                        end
                        fqd_pkg::ACT_QUERY: begin
                            res_load = 1'b1;
                        end
                    endcase
                end
            end
            fqd_pkg::ST_DEQ: begin
                res_load   = 1'b1;
                res_value  = mem_rdata_reg;
                head_next  = head_reg + PB'(1);
                count_next = count_reg - CB'(1);
                res_count  = count_next;
                state_next = fqd_pkg::ST_IDLE;
            end
            fqd_pkg::ST_SCAN: begin
                // read data belongs to offset idx_reg
                if (mem_rdata_reg == key_reg) begin
                    if (idx_inc1 < count_reg) begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg + idx_inc1[PB-1:0];
                        state_next = fqd_pkg::ST_SHIFT;
                    end else begin
                        // match is the newest entry: nothing to move
                        count_next = count_reg - CB'(1);
                        res_count  = count_next;
                        res_load   = 1'b1;
                        state_next = fqd_pkg::ST_IDLE;
                    end
                end else if (idx_inc1 < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = head_reg + idx_inc1[PB-1:0];
                    idx_next  = idx_inc1[PB-1:0];
                end else begin
                    res_load   = 1'b1;
                    res_status = fqd_pkg::STAT_REJECT;
                    state_next = fqd_pkg::ST_IDLE;
                end
            end
            fqd_pkg::ST_SHIFT: begin
                // entry at idx+1 moves down to idx; the next read is two
                // slots ahead, so it never meets this write
                mem_we    = 1'b1;
                mem_waddr = head_reg + idx_reg;
                mem_wdata = mem_rdata_reg;
                if (idx_inc2 < count_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = head_reg + idx_inc2[PB-1:0];
                    idx_next  = idx_inc1[PB-1:0];
                end else begin
                    count_next = count_reg - CB'(1);
                    res_count  = count_next;
                    res_load   = 1'b1;
                    state_next = fqd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fqd_pkg::ST_IDLE;
            end
        endcase
    end

    // entry memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= entry_mem[mem_raddr];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fqd_pkg::ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (res_load) begin
            res_status_reg <= res_status;
            res_value_reg  <= res_value;
            res_count_reg  <= res_count;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_count_reg, res_value_reg, res_status_reg};

`ifndef SYNTHESIS
    // occupancy never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fqd_pkg::FULL_COUNT)
        else $error("entry count above depth");

    // no item is taken while the controller is busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != fqd_pkg::ST_IDLE |-> !s_tready)
        else $error("item accepted during multi-cycle work");

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && m_tvalid_reg |-> m_tready)
        else $error("result register overwritten");

    // gap closing only happens with at least two entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fqd_pkg::ST_SHIFT |-> count_reg >= CB'(2))
        else $error("shift with fewer than two entries");

    // a busy scan keeps its offset inside the held entries
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == fqd_pkg::ST_SCAN |-> {1'b0, idx_reg} < count_reg)
        else $error("scan offset beyond queue length");
`endif

endmodule
